### rtl/lzwse_pkg.sv
// Package for the LZW stream encoder: sizes, the search token and the
// dictionary write bundle, plus code width helpers. No dependencies.
package lzwse_pkg;

    localparam int DICT_CODE_BITS = 12;
    localparam int LITERAL_CODES  = 256;
    localparam int MIN_CODE_BITS  = 9;
    localparam int CELL_BITS      = 4;
    localparam int NUM_CELLS      = 1 << CELL_BITS;
    localparam int ROW_BITS       = DICT_CODE_BITS - CELL_BITS;
    localparam int KEY_W          = DICT_CODE_BITS + 8;
    localparam int NFC_W          = DICT_CODE_BITS + 1;
    localparam int BITS_W         = 4;
    localparam int FIRST_ROW      = LITERAL_CODES / NUM_CELLS;

    typedef struct packed {
        logic                      valid;
        logic [ROW_BITS-1:0]       row;
        logic                      hit;
        logic [DICT_CODE_BITS-1:0] code;
    } t_tok;

    typedef struct packed {
        logic                 en;
        logic [CELL_BITS-1:0] slot;
        logic [ROW_BITS-1:0]  row;
        logic [KEY_W-1:0]     key;
    } t_wr;

    function automatic logic [BITS_W-1:0] f_eff_bits(input logic [BITS_W-1:0] r);
        logic [BITS_W-1:0] b;
        b = r;
        if (r < BITS_W'(MIN_CODE_BITS)) b = BITS_W'(MIN_CODE_BITS);
        else if (r > BITS_W'(DICT_CODE_BITS)) b = BITS_W'(DICT_CODE_BITS);
        return b;
    endfunction

    function automatic logic [BITS_W-1:0] f_width_now(input logic [NFC_W-1:0] nfc,
                                                      input logic [BITS_W-1:0] cap);
        logic [4:0] bl;
        bl = 5'd0;
        for (int i = 0; i < NFC_W; i++) begin
            if (nfc[i]) bl = 5'(i + 1);
        end
        if (bl < 5'(MIN_CODE_BITS)) bl = 5'(MIN_CODE_BITS);
        if (bl > {1'b0, cap}) bl = {1'b0, cap};
        return bl[BITS_W-1:0];
    endfunction

endpackage

### rtl/lzwse_if.sv
// Stream channel interfaces for the LZW encoder: byte input and code output.
// Depends on nothing.
interface lzwse_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       last_byte;
    modport source (output valid, output in_byte, output last_byte, input ready);
    modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

interface lzwse_out_if;
    logic        valid;
    logic        ready;
    logic [11:0] out_code;
    logic [3:0]  code_bits;
    logic        end_of_run;
    modport source (output valid, output out_code, output code_bits, output end_of_run,
                    input ready);
    modport sink   (input valid, input out_code, input code_bits, input end_of_run,
                    output ready);
endinterface

### rtl/lzwse_cell.sv
// One dictionary cell: a slice of the dictionary memory and one compare stage.
// Depends on lzwse_pkg.
module lzwse_cell import lzwse_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [CELL_BITS-1:0] i_cell_id,
    input  t_tok                 i_tok,
    input  logic [KEY_W-1:0]     i_key,
    input  logic [NFC_W-1:0]     i_nfc,
    input  t_wr                  i_wr,
    output t_tok                 o_tok
);
    logic [KEY_W-1:0] mem [1 << ROW_BITS];
    logic [KEY_W-1:0] r_rd;
    t_tok             r_tok;
    logic [DICT_CODE_BITS-1:0] own_code;
    logic             match;

    always_ff @(posedge i_clk) begin
        if (i_wr.en && i_wr.slot == i_cell_id) begin
            mem[i_wr.row] <= i_wr.key;
        end
        r_rd <= mem[i_tok.row];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= i_tok;
        end
    end

    assign own_code = {r_tok.row, i_cell_id};
    assign match    = r_tok.valid && (r_rd == i_key) && ({1'b0, own_code} < i_nfc);

    always_comb begin
        o_tok       = r_tok;
        o_tok.hit   = r_tok.hit | match;
        o_tok.code  = r_tok.hit ? r_tok.code : own_code;
    end
endmodule

### rtl/lzwse_chain.sv
// Row of dictionary cells; the search token moves one cell per cycle.
// Depends on lzwse_pkg and lzwse_cell.
module lzwse_chain import lzwse_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_tok             i_tok,
    input  logic [KEY_W-1:0] i_key,
    input  logic [NFC_W-1:0] i_nfc,
    input  t_wr              i_wr,
    output t_tok             o_tok
);
    t_tok tok [NUM_CELLS+1];

    assign tok[0] = i_tok;

    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        lzwse_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_cell_id (CELL_BITS'(g)),
            .i_tok     (tok[g]),
            .i_key     (i_key),
            .i_nfc     (i_nfc),
            .i_wr      (i_wr),
            .o_tok     (tok[g+1])
        );
    end

    assign o_tok = tok[NUM_CELLS];
endmodule

### rtl/lzw_stream_encoder_core.sv
// LZW stream encoder top level: control sequencer, cell chain, APB register.
// Depends on lzwse_pkg, lzwse_if, lzwse_chain.
//
// Usage: bytes enter on i_in (valid/ready, transfer when both high) with
// last_byte marking the end of a stream. Codes leave on o_out from an output
// register, each with width code_bits; end_of_run flags a stream's last code. The
// user must write max_code_bits (APB, paddr[2] low, so address 0) only while idle.
// The block does not enforce this. One byte is handled at a time. A byte with
// no prefix yet just becomes the prefix. Otherwise the dictionary is searched
// row by row through a chain of 16 cells: the rows from 16 up to the row of
// next_free_code - 1 are injected, the chain drains, a decision state follows,
// and on a miss the prefix code is emitted. The cost of a byte is set by the
// row count of the dictionary and the chain depth.
// Reset empties the dictionary (by next_free_code = 256), clears the prefix,
// sets max_code_bits to 12. No clearing pass is needed.
// When the receiver stalls, a pending code holds in the output register and
// the sequencer waits before loading the next one; no input is taken.
module lzw_stream_encoder_core import lzwse_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    lzwse_in_if.sink          i_in,
    lzwse_out_if.source       o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DRAIN  = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_MISS   = 3'd4;
    localparam logic [2:0] S_FLUSH  = 3'd5;

    logic [2:0]                r_state, n_state;
    logic [NFC_W-1:0]          r_nfc, n_nfc;
    logic [DICT_CODE_BITS-1:0] r_prefix, n_prefix;
    logic                      r_present, n_present;
    logic [7:0]                r_byte, n_byte;
    logic                      r_last, n_last;
    logic [ROW_BITS-1:0]       r_k, n_k;
    logic [CELL_BITS-1:0]      r_cnt, n_cnt;
    logic                      r_found, n_found;
    logic [DICT_CODE_BITS-1:0] r_fcode, n_fcode;
    logic [BITS_W-1:0]         r_maxbits;

    logic                      r_ovalid;
    logic [11:0]               r_ocode;
    logic [3:0]                r_obits;
    logic                      r_oend;

    logic                      load;
    logic                      ld_end;
    logic                      out_free;
    logic                      in_xfer;
    logic [BITS_W-1:0]         eff;
    logic [BITS_W-1:0]         wnow;
    logic [NFC_W-1:0]          room;
    logic [NFC_W-1:0]          nfc_m1;
    logic [ROW_BITS-1:0]       k_end;
    t_tok                      head_tok, tail_tok;
    t_wr                       wr;
    logic [KEY_W-1:0]          key;

    assign pready   = 1'b1;
    assign prdata   = {{(32-BITS_W){1'b0}}, r_maxbits};

    assign eff      = f_eff_bits(r_maxbits);
    assign wnow     = f_width_now(r_nfc, eff);
    assign room     = NFC_W'(1) << eff;
    assign nfc_m1   = r_nfc - NFC_W'(1);
    assign k_end    = nfc_m1[DICT_CODE_BITS-1:CELL_BITS];
    assign key      = {r_prefix, r_byte};
    assign out_free = !r_ovalid || o_out.ready;
    assign in_xfer  = i_in.valid && i_in.ready;

    assign i_in.ready       = (r_state == S_IDLE);
    assign o_out.valid      = r_ovalid;
    assign o_out.out_code   = r_ocode;
    assign o_out.code_bits  = r_obits;
    assign o_out.end_of_run = r_oend;

    lzwse_chain u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tok   (head_tok),
        .i_key   (key),
        .i_nfc   (r_nfc),
        .i_wr    (wr),
        .o_tok   (tail_tok)
    );

    always_comb begin
        n_state   = r_state;
        n_nfc     = r_nfc;
        n_prefix  = r_prefix;
        n_present = r_present;
        n_byte    = r_byte;
        n_last    = r_last;
        n_k       = r_k;
        n_cnt     = r_cnt;
        n_found   = r_found;
        n_fcode   = r_fcode;
        load      = 1'b0;
        ld_end    = 1'b0;
        head_tok  = '0;
        wr.en     = 1'b0;
        wr.slot   = r_nfc[CELL_BITS-1:0];
        wr.row    = r_nfc[DICT_CODE_BITS-1:CELL_BITS];
        wr.key    = key;

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_byte  = i_in.in_byte;
                    n_last  = i_in.last_byte;
                    n_found = 1'b0;
                    if (!r_present) begin
                        n_prefix  = {{(DICT_CODE_BITS-8){1'b0}}, i_in.in_byte};
                        n_present = 1'b1;
                        if (i_in.last_byte) n_state = S_FLUSH;
                    end else if (r_nfc == NFC_W'(LITERAL_CODES)) begin
                        n_state = S_MISS;
                    end else begin
                        n_k     = ROW_BITS'(FIRST_ROW);
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                head_tok.valid = 1'b1;
                head_tok.row   = r_k;
                n_k            = r_k + ROW_BITS'(1);
                if (r_k == k_end) begin
                    n_cnt   = '0;
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_cnt = r_cnt + CELL_BITS'(1);
                if (r_cnt == CELL_BITS'(NUM_CELLS - 1)) n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (r_found) begin
                    n_prefix = r_fcode;
                    n_state  = r_last ? S_FLUSH : S_IDLE;
                end else begin
                    n_state = S_MISS;
                end
            end
            S_MISS: begin
                if (out_free) begin
                    load = 1'b1;
                    if (r_nfc < room) begin
                        wr.en = 1'b1;
                        n_nfc = r_nfc + NFC_W'(1);
                    end
                    n_prefix = {{(DICT_CODE_BITS-8){1'b0}}, r_byte};
                    n_state  = r_last ? S_FLUSH : S_IDLE;
                end
            end
            S_FLUSH: begin
                if (out_free) begin
                    load      = 1'b1;
                    ld_end    = 1'b1;
                    n_nfc     = NFC_W'(LITERAL_CODES);
                    n_present = 1'b0;
                    n_prefix  = '0;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (tail_tok.valid && tail_tok.hit && !r_found) begin
            n_found = 1'b1;
            n_fcode = tail_tok.code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_nfc     <= NFC_W'(LITERAL_CODES);
            r_prefix  <= '0;
            r_present <= 1'b0;
            r_last    <= 1'b0;
            r_k       <= '0;
            r_cnt     <= '0;
            r_found   <= 1'b0;
            r_ovalid  <= 1'b0;
            r_maxbits <= BITS_W'(DICT_CODE_BITS);
        end else begin
            r_state   <= n_state;
            r_nfc     <= n_nfc;
            r_prefix  <= n_prefix;
            r_present <= n_present;
            r_last    <= n_last;
            r_k       <= n_k;
            r_cnt     <= n_cnt;
            r_found   <= n_found;
            if (load) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            if (psel && penable && pwrite && !paddr[2]) begin
                r_maxbits <= pwdata[BITS_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte  <= n_byte;
        r_fcode <= n_fcode;
        if (load) begin
            r_ocode <= r_prefix;
            r_obits <= wnow;
            r_oend  <= ld_end;
        end
    end
endmodule
